FILE: rtl/pwic_pkg.sv
// shared types and constants for the pid controller with integral cutoff
`timescale 1ns / 1ps
`default_nettype none

package pwic_pkg;

    localparam int GAIN_W  = 32;
    localparam int ERR_W   = 32;
    localparam int BAND_W  = 31;
    localparam int ELAP_W  = 16;
    localparam int INTEG_W = 64;
    localparam int OPND_W  = 33;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = 98;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_BAND = 2'd3;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic                     vld;
        t_acc_op                  op;
        logic                     shift32;
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } t_mac_cmd;

endpackage

`default_nettype wire

FILE: rtl/pid_with_integral_cutoff.sv
// pid controller top level: sequencer, state, config registers and output register
// update transaction: the result waits for the divider that forms the derivative;
// the multiplier passes for the proportional and integral terms overlap it
// clear transaction: zeroes integral and previous error and loads a zero drive
// a finished result waits in the output register while the next one is accepted
// synchronous active-low reset clears gains, band, integral and previous error
`timescale 1ns / 1ps
`default_nettype none

module pid_with_integral_cutoff import pwic_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [GAIN_W-1:0]        i_cfg_data,
    input  wire logic                     i_in_vld,
    output logic                          o_in_stall,
    input  wire logic                     i_action,
    input  wire logic signed [ERR_W-1:0]  i_measured,
    input  wire logic signed [ERR_W-1:0]  i_setpoint,
    input  wire logic [ELAP_W-1:0]        i_elapsed_ms,
    output logic                          o_out_vld,
    input  wire logic                     i_out_stall,
    output logic signed [ERR_W-1:0]       o_drive,
    output logic signed [INTEG_W-1:0]     o_integral_now
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MULIE,
        S_INTEG,
        S_MULLO,
        S_MULHI,
        S_DIVW,
        S_MULD,
        S_FLUSH,
        S_SAT,
        S_OUT
    } t_state;

    t_state                     r_state;
    logic signed [GAIN_W-1:0]   r_kp;
    logic signed [GAIN_W-1:0]   r_ki;
    logic signed [GAIN_W-1:0]   r_kd;
    logic [BAND_W-1:0]          r_band;
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [ERR_W-1:0]    r_prev;
    logic signed [ERR_W-1:0]    r_err;
    logic [ELAP_W-1:0]          r_elapsed;
    logic                       r_in_band;
    logic                       r_dzero;
    logic signed [ERR_W-1:0]    r_res_drive;
    logic                       r_out_vld;
    logic signed [ERR_W-1:0]    r_out_drive;
    logic signed [INTEG_W-1:0]  r_out_integ;

    logic                       w_in_acc;
    logic signed [ERR_W:0]      w_diff;
    logic signed [ERR_W-1:0]    w_err_sat;
    logic [ERR_W:0]             w_mag;
    logic                       w_band_ok;
    logic signed [OPND_W-1:0]   w_ddelta;
    logic signed [INTEG_W:0]    w_sum;
    logic signed [INTEG_W-1:0]  n_integ;
    logic                       w_fits;
    logic signed [ERR_W-1:0]    w_drive;
    t_mac_cmd                   w_cmd;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]    w_acc;
    logic                       w_div_start;
    logic                       w_div_done;
    logic signed [OPND_W-1:0]   w_quot;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_vld && !o_in_stall;

    // error with clamp to 32 bits
    assign w_diff    = {i_setpoint[ERR_W-1], i_setpoint} - {i_measured[ERR_W-1], i_measured};
    assign w_err_sat = (w_diff[ERR_W] != w_diff[ERR_W-1])
                     ? (w_diff[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}})
                     : w_diff[ERR_W-1:0];

    assign w_mag     = r_err[ERR_W-1] ? ((ERR_W+1)'(0) - {r_err[ERR_W-1], r_err})
                                      : {1'b0, r_err};
    assign w_band_ok = (r_band == '0) || (w_mag <= {2'b00, r_band});

    assign w_ddelta  = {r_err[ERR_W-1], r_err} - {r_prev[ERR_W-1], r_prev};

    // saturating 64-bit add of error times elapsed time
    assign w_sum   = {r_integ[INTEG_W-1], r_integ}
                   + {{(INTEG_W+1-48){w_prod[47]}}, w_prod[47:0]};
    assign n_integ = (w_sum[INTEG_W] != w_sum[INTEG_W-1])
                   ? (w_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}})
                   : w_sum[INTEG_W-1:0];

    // floor shift by 16 then clamp to 32 bits
    assign w_fits  = (w_acc[ACC_W-1:47] == '0) || (w_acc[ACC_W-1:47] == '1);
    assign w_drive = w_fits ? w_acc[47:16]
                   : (w_acc[ACC_W-1] ? {1'b1, {(ERR_W-1){1'b0}}}
                                     : {1'b0, {(ERR_W-1){1'b1}}});

    assign w_div_start = (r_state == S_MULIE);

    always_comb begin
        w_cmd         = '0;
        w_cmd.op      = ACC_HOLD;
        case (r_state)
            S_MULIE: begin
                w_cmd.vld = 1'b1;
                w_cmd.a   = {r_err[ERR_W-1], r_err};
                w_cmd.b   = {{(OPND_W-ELAP_W){1'b0}}, r_elapsed};
            end
            S_INTEG: begin
                w_cmd.vld = 1'b1;
                w_cmd.op  = ACC_LOAD;
                w_cmd.a   = {r_err[ERR_W-1], r_err};
                w_cmd.b   = {r_kp[GAIN_W-1], r_kp};
            end
            S_MULLO: begin
                w_cmd.vld = 1'b1;
                w_cmd.op  = ACC_ADD;
                w_cmd.a   = {1'b0, r_integ[31:0]};
                w_cmd.b   = {r_ki[GAIN_W-1], r_ki};
            end
            S_MULHI: begin
                w_cmd.vld     = 1'b1;
                w_cmd.op      = ACC_ADD;
                w_cmd.shift32 = 1'b1;
                w_cmd.a       = {r_integ[INTEG_W-1], r_integ[INTEG_W-1:32]};
                w_cmd.b       = {r_ki[GAIN_W-1], r_ki};
            end
            S_MULD: begin
                w_cmd.vld = 1'b1;
                w_cmd.op  = ACC_SUB;
                w_cmd.a   = r_dzero ? '0 : w_quot;
                w_cmd.b   = {r_kd[GAIN_W-1], r_kd};
            end
            default: begin
                w_cmd.vld = 1'b0;
            end
        endcase
    end

    pwic_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_prod  (w_prod),
        .o_acc   (w_acc)
    );

    pwic_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_ddelta),
        .i_divisor  (r_elapsed),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_kp      <= '0;
            r_ki      <= '0;
            r_kd      <= '0;
            r_band    <= '0;
            r_integ   <= '0;
            r_prev    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROP_GAIN:  r_kp   <= i_cfg_data;
                    CFG_INTEG_GAIN: r_ki   <= i_cfg_data;
                    CFG_DERIV_GAIN: r_kd   <= i_cfg_data;
                    CFG_INTEG_BAND: r_band <= i_cfg_data[BAND_W-1:0];
                    default:        r_band <= r_band;
                endcase
            end

            // in S_OUT the output register is handled by the load below
            if (r_out_vld && !i_out_stall && r_state != S_OUT) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_action) begin
                            r_integ     <= '0;
                            r_prev      <= '0;
                            r_res_drive <= '0;
                            r_state     <= S_OUT;
                        end else begin
                            r_err     <= w_err_sat;
                            r_elapsed <= i_elapsed_ms;
                            r_state   <= S_MULIE;
                        end
                    end
                end
                S_MULIE: begin
                    r_in_band <= w_band_ok;
                    r_dzero   <= (r_prev == '0) || (r_elapsed == '0);
                    r_prev    <= r_err;
                    r_state   <= S_INTEG;
                end
                S_INTEG: begin
                    r_integ <= r_in_band ? n_integ : '0;
                    r_state <= S_MULLO;
                end
                S_MULLO: r_state <= S_MULHI;
                S_MULHI: r_state <= S_DIVW;
                S_DIVW: begin
                    if (w_div_done) begin
                        r_state <= S_MULD;
                    end
                end
                S_MULD:  r_state <= S_FLUSH;
                S_FLUSH: r_state <= S_SAT;
                S_SAT: begin
                    r_res_drive <= w_drive;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_out_vld   <= 1'b1;
                        r_out_drive <= r_res_drive;
                        r_out_integ <= r_integ;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_vld      = r_out_vld;
    assign o_drive        = r_out_drive;
    assign o_integral_now = r_out_integ;

    a_clear_zeroes_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_action) |=> (r_integ == '0 && r_prev == '0))
        else $error("clear transaction did not zero the state");

    a_out_of_band_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INTEG && !r_in_band) |=> (r_integ == '0))
        else $error("integral not cleared outside the band");

    a_div_ready_for_deriv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULD) |-> w_div_done)
        else $error("derivative product issued before the quotient was ready");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_vld || !i_out_stall)) |=> (r_out_vld && r_state == S_IDLE))
        else $error("finished result was not moved to the output register");

endmodule

`default_nettype wire

FILE: rtl/pwic_div.sv
// radix-2 restoring divider, one quotient bit per cycle, truncates toward zero
`timescale 1ns / 1ps
`default_nettype none

module pwic_div import pwic_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [OPND_W-1:0] i_dividend,
    input  wire logic [ELAP_W-1:0]        i_divisor,
    output logic                          o_done,
    output logic signed [OPND_W-1:0]      o_quot
);

    localparam int MAG_W = OPND_W - 1;
    localparam int CNT_W = $clog2(MAG_W);

    logic                r_run;
    logic                r_done;
    logic                r_neg;
    logic [CNT_W-1:0]    r_cnt;
    logic [MAG_W-1:0]    r_num;
    logic [ELAP_W-1:0]   r_rem;
    logic [ELAP_W-1:0]   r_div;

    logic [OPND_W-1:0]   w_mag;
    logic [ELAP_W:0]     w_trial;
    logic                w_qbit;
    logic [ELAP_W:0]     w_diff;
    logic [ELAP_W-1:0]   n_rem;

    // dividend magnitude always fits in MAG_W bits (difference of two 32-bit values)
    assign w_mag   = i_dividend[OPND_W-1] ? (OPND_W'(0) - OPND_W'(i_dividend))
                                          : OPND_W'(i_dividend);
    assign w_trial = {r_rem, r_num[MAG_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};
    assign n_rem   = w_qbit ? w_diff[ELAP_W-1:0] : w_trial[ELAP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_neg  <= i_dividend[OPND_W-1];
            r_num  <= w_mag[MAG_W-1:0];
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_cnt  <= '1;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_num <= {r_num[MAG_W-2:0], w_qbit};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (OPND_W'(0) - {1'b0, r_num}) : {1'b0, r_num};

endmodule

`default_nettype wire

FILE: rtl/pwic_mac.sv
// shared signed multiplier with product register and wide accumulator
`timescale 1ns / 1ps
`default_nettype none

module pwic_mac import pwic_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_mac_cmd                i_cmd,
    output logic signed [PROD_W-1:0]     o_prod,
    output logic signed [ACC_W-1:0]      o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    t_acc_op                  r_op;
    logic                     r_sh;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [ACC_W-1:0]  w_ext;
    logic signed [ACC_W-1:0]  w_term;

    assign w_ext  = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_term = r_sh ? (w_ext <<< 32) : w_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= ACC_HOLD;
        end else begin
            if (i_cmd.vld) begin
                r_prod <= i_cmd.a * i_cmd.b;
                r_op   <= i_cmd.op;
                r_sh   <= i_cmd.shift32;
            end else begin
                r_op <= ACC_HOLD;
            end
            case (r_op)
                ACC_LOAD: r_acc <= w_term;
                ACC_ADD:  r_acc <= r_acc + w_term;
                ACC_SUB:  r_acc <= r_acc - w_term;
                default:  r_acc <= r_acc;
            endcase
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire
